// ===== src/tsk_pkg.sv =====
// Shared types and constants for the topological sort block.
// Used by tsk_edge_store and topological_sort_kahn; depends on nothing else.
package tsk_pkg;

    localparam int MAX_NODES = 64;
    localparam int MAX_EDGES = 256;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = NODE_W + 1;
    localparam int EDGE_W    = $clog2(MAX_EDGES);
    localparam int ECNT_W    = EDGE_W + 1;
    localparam int DEG_W     = ECNT_W;
    localparam int CFG_W     = 7;
    localparam int FIELD_W   = 6;

    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_SORT = 1'b1;

    typedef logic [NODE_W-1:0] node_idx_t;
    typedef logic [EDGE_W-1:0] edge_idx_t;

    typedef struct packed {
        logic               func;
        logic [FIELD_W-1:0] edge_from;
        logic [FIELD_W-1:0] edge_to;
    } item_t;

    typedef struct packed {
        logic [FIELD_W-1:0] node;
        logic               node_valid;
        logic               last;
        logic               cycle_found;
        logic               edge_overflow;
    } result_t;

    typedef struct packed {
        logic      tgt_we;
        edge_idx_t tgt_addr;
        node_idx_t tgt_data;
        logic      nxt_we;
        edge_idx_t nxt_addr;
        edge_idx_t nxt_data;
        edge_idx_t rd_addr;
    } edge_cmd_t;

    typedef struct packed {
        node_idx_t tgt;
        edge_idx_t nxt;
    } edge_rd_t;

endpackage

// ===== src/tsk_edge_store.sv =====
// Edge store: target node and next-edge link of every stored edge.
// Two single-port-write memories sharing one read address, with registered read data; uses tsk_pkg.
module tsk_edge_store
    import tsk_pkg::*;
(
    input  logic      clk,
    input  edge_cmd_t cmd,
    output edge_rd_t  rd
);

    node_idx_t tgt_mem [MAX_EDGES];
    edge_idx_t nxt_mem [MAX_EDGES];

    // The two fields are written at different addresses when an edge is
    // appended behind the old tail of a list, so each has its own port.
    always_ff @(posedge clk)
    begin
        if (cmd.tgt_we)
        begin
            tgt_mem[cmd.tgt_addr] <= cmd.tgt_data;
        end
        if (cmd.nxt_we)
        begin
            nxt_mem[cmd.nxt_addr] <= cmd.nxt_data;
        end
        rd.tgt <= tgt_mem[cmd.rd_addr];
        rd.nxt <= nxt_mem[cmd.rd_addr];
    end

endmodule

// ===== src/topological_sort_kahn.sv =====
// Kahn topological sort over a graph held in on-chip memories.
// Depends on tsk_pkg and tsk_edge_store.
//
//   channel   handshake             payload    direction
//   item      start / busy          item       in
//   result    result_valid strobe   result     out
//   config    cfg_valid / cfg_ready cfg_data   in
//
// An add-edge item keeps busy high while it reads the tail and in-degree and
// then writes them back, or only for the read when the edge is ignored or
// dropped. A sort item keeps busy high for the scan of the nodes in use, the
// emitted nodes and the edges walked: the scan reads one in-degree per cycle,
// each node costs a pop and a list-head read, and each edge costs a read of
// the edge store, a read of the in-degree memory and its write back.
// The final result comes in the same cycle that busy drops. Reset and the end of
// every sort clear the valid bits of the in-degree and list-head memories at once.
// Results are strobed for one cycle each; the receiver cannot stall them.
module topological_sort_kahn
    import tsk_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  item_t            item,
    output logic             result_valid,
    output result_t          result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ADD_RD   = 4'd1;
    localparam logic [3:0] S_ADD_WR   = 4'd2;
    localparam logic [3:0] S_SCAN     = 4'd3;
    localparam logic [3:0] S_POP      = 4'd4;
    localparam logic [3:0] S_POP_WAIT = 4'd5;
    localparam logic [3:0] S_HEAD     = 4'd6;
    localparam logic [3:0] S_EDGE_RD  = 4'd7;
    localparam logic [3:0] S_EDGE_DAT = 4'd8;
    localparam logic [3:0] S_DEG      = 4'd9;

    logic [3:0]           state_reg, state_next;
    logic [CFG_W-1:0]     node_count_reg;
    node_idx_t            from_reg, from_next;
    node_idx_t            to_reg, to_next;
    logic [ECNT_W-1:0]    edges_reg, edges_next;
    logic                 ovf_reg, ovf_next;
    logic [MAX_NODES-1:0] deg_vld_reg, deg_vld_next;
    logic [MAX_NODES-1:0] head_vld_reg, head_vld_next;
    logic [CNT_W-1:0]     scan_reg, scan_next;
    logic                 chk_reg, chk_next;
    node_idx_t            chk_idx_reg, chk_idx_next;
    logic [CNT_W-1:0]     rp_reg, rp_next;
    logic [CNT_W-1:0]     wp_reg, wp_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 pend_valid_reg, pend_valid_next;
    node_idx_t            pend_node_reg, pend_node_next;
    edge_idx_t            cur_e_reg, cur_e_next;
    edge_idx_t            tail_e_reg, tail_e_next;
    edge_idx_t            nxt_e_reg, nxt_e_next;
    node_idx_t            w_reg, w_next;
    logic                 last_edge_reg, last_edge_next;
    result_t              res_reg, res_next;
    logic                 res_valid_reg, res_valid_next;

    logic [DEG_W-1:0]     deg_mem [MAX_NODES];
    edge_idx_t            head_mem [MAX_NODES];
    edge_idx_t            tail_mem [MAX_NODES];
    node_idx_t            q_mem [MAX_NODES];
    logic [DEG_W-1:0]     deg_rd_reg;
    logic                 deg_rv_reg;
    edge_idx_t            head_rd_reg;
    edge_idx_t            tail_rd_reg;
    node_idx_t            q_rd_reg;

    node_idx_t            deg_raddr, deg_waddr, node_raddr, node_waddr;
    logic                 deg_we, head_we, tail_we, q_we;
    logic [DEG_W-1:0]     deg_wdata, deg_eff;
    edge_idx_t            node_wdata;
    logic                 push;
    node_idx_t            push_node;
    logic [CNT_W-1:0]     n_eff;
    edge_cmd_t            ecmd;
    edge_rd_t             erd;

    tsk_edge_store u_edges (
        .clk (clk),
        .cmd (ecmd),
        .rd  (erd)
    );

    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    assign n_eff   = (node_count_reg > CFG_W'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                          : CNT_W'(node_count_reg);
    // An entry whose valid bit is clear holds a zero in-degree.
    assign deg_eff = deg_rv_reg ? deg_rd_reg : '0;

    always_comb
    begin
        state_next      = state_reg;
        from_next       = from_reg;
        to_next         = to_reg;
        edges_next      = edges_reg;
        ovf_next        = ovf_reg;
        deg_vld_next    = deg_vld_reg;
        head_vld_next   = head_vld_reg;
        scan_next       = scan_reg;
        chk_next        = chk_reg;
        chk_idx_next    = chk_idx_reg;
        rp_next         = rp_reg;
        wp_next         = wp_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        pend_node_next  = pend_node_reg;
        cur_e_next      = cur_e_reg;
        tail_e_next     = tail_e_reg;
        nxt_e_next      = nxt_e_reg;
        w_next          = w_reg;
        last_edge_next  = last_edge_reg;
        res_next        = res_reg;
        res_valid_next  = 1'b0;

        deg_raddr  = '0;
        deg_waddr  = '0;
        deg_wdata  = '0;
        deg_we     = 1'b0;
        node_raddr = '0;
        node_waddr = from_reg;
        node_wdata = edges_reg[EDGE_W-1:0];
        head_we    = 1'b0;
        tail_we    = 1'b0;
        q_we       = 1'b0;
        push       = 1'b0;
        push_node  = '0;

        ecmd          = '0;
        ecmd.tgt_addr = edges_reg[EDGE_W-1:0];
        ecmd.tgt_data = to_reg;
        ecmd.nxt_addr = tail_rd_reg;
        ecmd.nxt_data = edges_reg[EDGE_W-1:0];
        ecmd.rd_addr  = cur_e_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    from_next = NODE_W'(item.edge_from);
                    to_next   = NODE_W'(item.edge_to);
                    if (item.func == FUNC_ADD)
                    begin
                        state_next = S_ADD_RD;
                    end
                    else
                    begin
                        scan_next       = '0;
                        chk_next        = 1'b0;
                        rp_next         = '0;
                        wp_next         = '0;
                        count_next      = '0;
                        pend_valid_next = 1'b0;
                        state_next      = S_SCAN;
                    end
                end
            end
            S_ADD_RD:
            begin
                deg_raddr  = to_reg;
                node_raddr = from_reg;
                if (({1'b0, from_reg} >= n_eff) || ({1'b0, to_reg} >= n_eff))
                begin
                    state_next = S_IDLE;
                end
                else if (edges_reg >= ECNT_W'(MAX_EDGES))
                begin
                    ovf_next   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_ADD_WR;
                end
            end
            S_ADD_WR:
            begin
                ecmd.tgt_we = 1'b1;
                if (head_vld_reg[from_reg])
                begin
                    ecmd.nxt_we = 1'b1;
                end
                else
                begin
                    head_we                 = 1'b1;
                    head_vld_next[from_reg] = 1'b1;
                end
                tail_we               = 1'b1;
                deg_we                = 1'b1;
                deg_waddr             = to_reg;
                deg_wdata             = deg_eff + DEG_W'(1);
                deg_vld_next[to_reg]  = 1'b1;
                edges_next            = edges_reg + ECNT_W'(1);
                state_next            = S_IDLE;
            end
            S_SCAN:
            begin
                // Reads run one node ahead of the zero test.
                deg_raddr = scan_reg[NODE_W-1:0];
                if (chk_reg && (deg_eff == '0))
                begin
                    push      = 1'b1;
                    push_node = chk_idx_reg;
                end
                if (scan_reg < n_eff)
                begin
                    chk_next     = 1'b1;
                    chk_idx_next = scan_reg[NODE_W-1:0];
                    scan_next    = scan_reg + CNT_W'(1);
                end
                else
                begin
                    chk_next = 1'b0;
                    if (!chk_reg)
                    begin
                        state_next = S_POP;
                    end
                end
            end
            S_POP:
            begin
                if (rp_reg < wp_reg)
                begin
                    rp_next    = rp_reg + CNT_W'(1);
                    state_next = S_POP_WAIT;
                end
                else
                begin
                    // The queue has run dry: the held node is the last one.
                    res_valid_next         = 1'b1;
                    res_next.node          = pend_valid_reg ? FIELD_W'(pend_node_reg) : '0;
                    res_next.node_valid    = pend_valid_reg;
                    res_next.last          = 1'b1;
                    res_next.cycle_found   = (count_reg < n_eff);
                    res_next.edge_overflow = ovf_reg;
                    deg_vld_next           = '0;
                    head_vld_next          = '0;
                    edges_next             = '0;
                    ovf_next               = 1'b0;
                    state_next             = S_IDLE;
                end
            end
            S_POP_WAIT:
            begin
                node_raddr = q_rd_reg;
                if (pend_valid_reg)
                begin
                    res_valid_next         = 1'b1;
                    res_next.node          = FIELD_W'(pend_node_reg);
                    res_next.node_valid    = 1'b1;
                    res_next.last          = 1'b0;
                    res_next.cycle_found   = 1'b0;
                    res_next.edge_overflow = 1'b0;
                end
                pend_valid_next = 1'b1;
                pend_node_next  = q_rd_reg;
                count_next      = count_reg + CNT_W'(1);
                state_next      = head_vld_reg[q_rd_reg] ? S_HEAD : S_POP;
            end
            S_HEAD:
            begin
                cur_e_next  = head_rd_reg;
                tail_e_next = tail_rd_reg;
                state_next  = S_EDGE_RD;
            end
            S_EDGE_RD:
            begin
                state_next = S_EDGE_DAT;
            end
            S_EDGE_DAT:
            begin
                deg_raddr      = erd.tgt;
                w_next         = erd.tgt;
                nxt_e_next     = erd.nxt;
                last_edge_next = (cur_e_reg == tail_e_reg);
                state_next     = S_DEG;
            end
            S_DEG:
            begin
                if (({1'b0, w_reg} < n_eff) && (deg_eff != '0))
                begin
                    deg_we    = 1'b1;
                    deg_waddr = w_reg;
                    deg_wdata = deg_eff - DEG_W'(1);
                    if (deg_eff == DEG_W'(1))
                    begin
                        push      = 1'b1;
                        push_node = w_reg;
                    end
                end
                if (last_edge_reg)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    cur_e_next = nxt_e_reg;
                    state_next = S_EDGE_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (push && (wp_reg < CNT_W'(MAX_NODES)))
        begin
            q_we    = 1'b1;
            wp_next = wp_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= CFG_W'(MAX_NODES);
            edges_reg      <= '0;
            ovf_reg        <= 1'b0;
            deg_vld_reg    <= '0;
            head_vld_reg   <= '0;
            scan_reg       <= '0;
            chk_reg        <= 1'b0;
            rp_reg         <= '0;
            wp_reg         <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            last_edge_reg  <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                node_count_reg <= cfg_data;
            end
            edges_reg      <= edges_next;
            ovf_reg        <= ovf_next;
            deg_vld_reg    <= deg_vld_next;
            head_vld_reg   <= head_vld_next;
            scan_reg       <= scan_next;
            chk_reg        <= chk_next;
            rp_reg         <= rp_next;
            wp_reg         <= wp_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            last_edge_reg  <= last_edge_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        from_reg      <= from_next;
        to_reg        <= to_next;
        chk_idx_reg   <= chk_idx_next;
        pend_node_reg <= pend_node_next;
        cur_e_reg     <= cur_e_next;
        tail_e_reg    <= tail_e_next;
        nxt_e_reg     <= nxt_e_next;
        w_reg         <= w_next;
        res_reg       <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (deg_we)
        begin
            deg_mem[deg_waddr] <= deg_wdata;
        end
        deg_rd_reg <= deg_mem[deg_raddr];
        deg_rv_reg <= deg_vld_reg[deg_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[node_waddr] <= node_wdata;
        end
        head_rd_reg <= head_mem[node_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tail_we)
        begin
            tail_mem[node_waddr] <= node_wdata;
        end
        tail_rd_reg <= tail_mem[node_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_mem[wp_reg[NODE_W-1:0]] <= push_node;
        end
        q_rd_reg <= q_mem[rp_reg[NODE_W-1:0]];
    end

    // The read pointer never passes the write pointer, which stays in bounds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rp_reg <= wp_reg) && (wp_reg <= CNT_W'(MAX_NODES)))
    else $error("ready queue pointers out of order");

    assert property (@(posedge clk) disable iff (!rst_n)
        edges_reg <= ECNT_W'(MAX_EDGES))
    else $error("edge count beyond capacity");

    // The final result of a sort returns the block to idle, and no result follows at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |-> (!busy ##1 !result_valid))
    else $error("result after the final item of a sort");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |->
            (result.node_valid && !result.cycle_found && !result.edge_overflow))
    else $error("flags on an item other than the last");

    // No more nodes are emitted than have been queued.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= wp_reg)
    else $error("more nodes emitted than queued");

endmodule

// ===== tb/sv/topological_sort_kahn_test.sv =====
// Self-checking testbench for topological_sort_kahn: directed and random graphs,
// with every result checked against a scoreboard that tracks the graph store.
// Depends on tsk_pkg and the topological_sort_kahn RTL.
`timescale 1ns / 1ps

module topological_sort_kahn_test;
    import tsk_pkg::*;

    localparam logic [ECNT_W-1:0] NO_EDGE = ECNT_W'(MAX_EDGES);

    class sort_scoreboard;
        logic [CFG_W-1:0]  node_count;
        logic [DEG_W-1:0]  in_degree [MAX_NODES];
        logic [ECNT_W-1:0] list_head [MAX_NODES];
        edge_idx_t         list_tail [MAX_NODES];
        node_idx_t         edge_target [MAX_EDGES];
        logic [ECNT_W-1:0] edge_next [MAX_EDGES];
        logic [ECNT_W-1:0] edges_stored;
        logic              overflow;
        result_t           pending [$];
        int                errors;

        function new();
            node_count = CFG_W'(MAX_NODES);
            errors = 0;
            clear_graph();
        endfunction

        function void clear_graph();
            for (int i = 0; i < MAX_NODES; i++)
            begin
                in_degree[i] = '0;
                list_head[i] = NO_EDGE;
                list_tail[i] = '0;
            end
            for (int i = 0; i < MAX_EDGES; i++)
            begin
                edge_target[i] = '0;
                edge_next[i] = NO_EDGE;
            end
            edges_stored = '0;
            overflow = 1'b0;
        endfunction

        function int active_nodes();
            return (node_count > MAX_NODES) ? MAX_NODES : int'(node_count);
        endfunction

        function void set_count(logic [CFG_W-1:0] value);
            node_count = value;
        endfunction

        function void store_edge(node_idx_t src, node_idx_t dst);
            int        n;
            edge_idx_t e;
            n = active_nodes();
            if (src >= n || dst >= n)
                return;
            if (edges_stored >= MAX_EDGES)
            begin
                overflow = 1'b1;
                return;
            end
            e = edges_stored[EDGE_W-1:0];
            edge_target[e] = dst;
            edge_next[e] = NO_EDGE;
            // Append to the tail so successors are walked in insertion order.
            if (list_head[src] == NO_EDGE)
                list_head[src] = {1'b0, e};
            else
                edge_next[list_tail[src]] = {1'b0, e};
            list_tail[src] = e;
            in_degree[dst] = in_degree[dst] + 1'b1;
            edges_stored = edges_stored + 1'b1;
        endfunction

        function void sort_graph();
            int                n;
            int                emitted;
            int                rd;
            int                wr;
            int                guard;
            node_idx_t         ready [MAX_NODES];
            node_idx_t         v;
            node_idx_t         w;
            logic [ECNT_W-1:0] e;
            result_t           r;
            n = active_nodes();
            rd = 0;
            wr = 0;
            emitted = 0;
            for (int i = 0; i < n; i++)
            begin
                if (in_degree[i] == 0)
                begin
                    ready[wr] = node_idx_t'(i);
                    wr++;
                end
            end
            while (rd < wr && emitted < MAX_NODES)
            begin
                v = ready[rd];
                rd++;
                r = '0;
                r.node = v;
                r.node_valid = 1'b1;
                pending.insert(pending.size(), r);
                emitted++;
                e = list_head[v];
                guard = 0;
                while (e < MAX_EDGES && guard < MAX_EDGES)
                begin
                    w = edge_target[e[EDGE_W-1:0]];
                    // Targets at or above the count in use are skipped.
                    if (w < n && in_degree[w] != 0)
                    begin
                        in_degree[w] = in_degree[w] - 1'b1;
                        if (in_degree[w] == 0 && wr < MAX_NODES)
                        begin
                            ready[wr] = w;
                            wr++;
                        end
                    end
                    e = edge_next[e[EDGE_W-1:0]];
                    guard++;
                end
            end
            if (emitted == 0)
            begin
                r = '0;
                pending.insert(pending.size(), r);
            end
            r = pending.pop_back();
            r.last = 1'b1;
            r.cycle_found = ((r.node_valid ? emitted : 0) < n);
            r.edge_overflow = overflow;
            pending.insert(pending.size(), r);
            clear_graph();
        endfunction

        function void note_item(item_t it);
            if (it.func == FUNC_SORT)
                sort_graph();
            else
                store_edge(it.edge_from, it.edge_to);
        endfunction

        function void compare(string name, int want, int got);
            if (want != got)
            begin
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: result expected none actual node %0d valid %0b last %0b",
                         $time, got.node, got.node_valid, got.last);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare("node", want.node, got.node);
            compare("node_valid", want.node_valid, got.node_valid);
            compare("last", want.last, got.last);
            compare("cycle_found", want.cycle_found, got.cycle_found);
            compare("edge_overflow", want.edge_overflow, got.edge_overflow);
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    item_t            item = '0;
    logic             cfg_valid = 1'b0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             busy;
    logic             result_valid;
    result_t          result;
    logic             cfg_ready;

    sort_scoreboard sb;
    int             items_sent;

    topological_sort_kahn dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_result(result);
    end

    function automatic item_t make_item(logic func, int src, int dst);
        item_t it;
        it.func = func;
        it.edge_from = node_idx_t'(src);
        it.edge_to = node_idx_t'(dst);
        return it;
    endfunction

    // Start stays high from one item to the next when no gap is drawn.
    task automatic send_item(item_t it);
        int gap;
        gap = $urandom_range(0, 6);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (busy);
        sb.note_item(it);
        items_sent++;
    endtask

    task automatic send_add(int src, int dst);
        send_item(make_item(FUNC_ADD, src, dst));
    endtask

    task automatic send_sort();
        send_item(make_item(FUNC_SORT, $urandom_range(0, 63), $urandom_range(0, 63)));
    endtask

    // The count is only changed once the block has gone quiet.
    task automatic write_count(int value);
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        while (busy)
            @(posedge clk);
        cfg_data <= CFG_W'(value);
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_count(CFG_W'(value));
    endtask

    // Mostly edges whose source is not above the target (self loops included),
    // plus some in-range edges in any direction and some anywhere in the field.
    task automatic random_graph(int adds);
        int n;
        int kind;
        int a;
        int b;
        int t;
        n = sb.active_nodes();
        repeat (adds)
        begin
            kind = $urandom_range(0, 9);
            a = $urandom_range(0, 63);
            b = $urandom_range(0, 63);
            if (kind >= 1 && n > 0)
            begin
                a = $urandom_range(0, n - 1);
                b = $urandom_range(0, n - 1);
                if (kind >= 2 && a > b)
                begin
                    t = a;
                    a = b;
                    b = t;
                end
            end
            send_add(a, b);
        end
    endtask

    initial
    begin
        int count_list [13] = '{64, 127, 16, 2, 100, 8, 64, 33, 1, 5, 64, 0, 12};
        int phase;
        int lowered;
        sb = new();
        items_sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty graph at the reset count: every node comes out in index order.
        send_sort();
        send_add(63, 0);
        send_add(0, 1);
        send_add(63, 1);
        send_add(1, 62);
        send_sort();
        send_add(2, 3);
        send_add(3, 2);
        send_add(4, 2);
        send_sort();

        // A single node on a self loop, plus edges out of range.
        write_count(1);
        send_add(0, 0);
        send_add(0, 1);
        send_add(63, 63);
        send_sort();

        // No nodes at all.
        write_count(0);
        send_add(0, 0);
        send_sort();

        // Lowering the count leaves edges from dropped nodes stranded.
        write_count(8);
        send_add(6, 3);
        send_add(2, 6);
        send_add(7, 5);
        send_add(0, 7);
        send_add(1, 2);
        write_count(6);
        send_sort();

        phase = 0;
        while (items_sent < 100)
        begin
            write_count(count_list[phase % $size(count_list)]);
            repeat ($urandom_range(1, 3))
            begin
                random_graph($urandom_range(0, 30));
                if ($urandom_range(0, 5) == 0 && sb.active_nodes() > 1)
                begin
                    lowered = $urandom_range(1, sb.active_nodes());
                    write_count(lowered);
                end
                send_sort();
            end
            phase++;
        end

        // Fill the edge store past capacity on a small graph.
        write_count(3);
        for (int i = 0; i < MAX_EDGES + 2; i++)
        begin
            send_add(i % 3, (i + 1) % 3);
        end
        send_sort();

        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/tsk_pkg.sv
src/tsk_edge_store.sv
src/topological_sort_kahn.sv
tb/sv/topological_sort_kahn_test.sv
